>>> sv/xtea_pkg.sv
// Shared types, constants and helper functions for the XTEA block cipher unit.
// No dependencies; imported by every module of the unit.
package xtea_pkg;

  // Round constant and default number of full cycles
  localparam logic [31:0] XTEA_DELTA  = 32'h9E37_79B9;
  localparam int          XTEA_ROUNDS = 32;

  // Register indexes of the configuration port
  typedef enum logic [1:0] {
    KEY_WORD0 = 2'd0,
    KEY_WORD1 = 2'd1,
    KEY_WORD2 = 2'd2,
    KEY_WORD3 = 2'd3
  } xtea_cfg_idx_t;

  // Operation codes of the kind field
  localparam logic KIND_ENCRYPT = 1'b0;
  localparam logic KIND_DECRYPT = 1'b1;

  // Input transaction
  typedef struct packed {
    logic        kind;
    logic [31:0] block_low;
    logic [31:0] block_high;
    logic [3:0]  valid_bytes;
  } xtea_in_t;

  // Result transaction
  typedef struct packed {
    logic [31:0] out_low;
    logic [31:0] out_high;
  } xtea_out_t;

  // Data carried down the round pipeline
  typedef struct packed {
    logic        kind;
    logic [31:0] y;
    logic [31:0] z;
  } xtea_stage_t;

  // The 128-bit key as four words
  typedef logic [3:0][31:0] xtea_key_t;

  // Running sum after n additions of delta, modulo 2^32 (elaboration only)
  function automatic logic [31:0] xtea_sum(input int n);
    logic [63:0] prod;
    prod = 64'(n) * 64'(XTEA_DELTA);
    return prod[31:0];
  endfunction

  // Feistel mixing of one half
  function automatic logic [31:0] xtea_mix(input logic [31:0] v);
    return ((v << 4) ^ (v >> 5)) + v;
  endfunction

endpackage

>>> sv/xtea_pad.sv
// Entry stage of the XTEA pipeline: registers the input transaction and
// zeroes the tail bytes of short blocks on encryption. Uses xtea_pkg.
module xtea_pad (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  xtea_pkg::xtea_in_t   in_data,
  output logic                 stg_valid,
  output xtea_pkg::xtea_stage_t stg_data
);
  import xtea_pkg::*;

  logic        valid_r;
  xtea_stage_t data_r;
  xtea_stage_t data_nxt;
  logic [7:0]  byte_keep;
  logic [63:0] block;

  // Byte keep mask: counts of zero or above eight mean a whole block
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      byte_keep[k] = (in_data.kind == KIND_DECRYPT) || (in_data.valid_bytes == 4'd0) ||
                     (in_data.valid_bytes >= 4'd8) || (4'(k) < in_data.valid_bytes);
    end
  end

  always_comb begin
    block = {in_data.block_high, in_data.block_low};
    for (int k = 0; k < 8; k++) begin
      if (!byte_keep[k]) begin
        block[8*k +: 8] = 8'h00;
      end
    end
    data_nxt.kind = in_data.kind;
    data_nxt.y    = block[31:0];
    data_nxt.z    = block[63:32];
  end

  // Valid travels with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign stg_valid = valid_r;
  assign stg_data  = data_r;

endmodule

>>> sv/xtea_half_round.sv
// One Feistel half-round stage of the XTEA pipeline, for both directions.
// The running sum and key index are constants of the stage. Uses xtea_pkg.
module xtea_half_round #(
  parameter int ROUNDS = xtea_pkg::XTEA_ROUNDS,
  parameter int HALF   = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  xtea_pkg::xtea_key_t   key,
  input  logic                  prev_valid,
  input  xtea_pkg::xtea_stage_t prev_data,
  output logic                  stg_valid,
  output xtea_pkg::xtea_stage_t stg_data
);
  import xtea_pkg::*;

  // Stage constants: n-th full cycle, odd half updates the other word
  localparam int          N     = HALF / 2;
  localparam bit          ODD   = (HALF % 2) == 1;
  localparam logic [31:0] SUM_E = xtea_sum(ODD ? N + 1 : N);
  localparam logic [1:0]  IDX_E = ODD ? SUM_E[12:11] : SUM_E[1:0];
  localparam logic [31:0] SUM_D = xtea_sum(ODD ? ROUNDS - N - 1 : ROUNDS - N);
  localparam logic [1:0]  IDX_D = ODD ? SUM_D[1:0] : SUM_D[12:11];

  logic        valid_r;
  xtea_stage_t data_r;
  xtea_stage_t data_nxt;
  logic        upd_y;
  logic [31:0] src;
  logic [31:0] dst;
  logic [31:0] rk;
  logic [31:0] f;
  logic [31:0] res;

  // Encrypt: even half updates y. Decrypt: odd half updates y.
  always_comb begin
    upd_y = (prev_data.kind == KIND_DECRYPT) == ODD;
    src   = upd_y ? prev_data.z : prev_data.y;
    dst   = upd_y ? prev_data.y : prev_data.z;
    rk    = (prev_data.kind == KIND_DECRYPT) ? (SUM_D + key[IDX_D])
                                             : (SUM_E + key[IDX_E]);
    f     = xtea_mix(src) ^ rk;
    res   = (prev_data.kind == KIND_DECRYPT) ? (dst - f) : (dst + f);
    data_nxt      = prev_data;
    if (upd_y) begin
      data_nxt.y = res;
    end else begin
      data_nxt.z = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign stg_valid = valid_r;
  assign stg_data  = data_r;

endmodule

>>> sv/xtea_out_skid.sv
// Output register with a one-entry skid buffer for the XTEA unit. The skid
// flag is registered and holds the whole pipeline. Uses xtea_pkg.
module xtea_out_skid (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  pipe_valid,
  input  xtea_pkg::xtea_stage_t pipe_data,
  output logic                  hold,
  output logic                  out_valid,
  input  logic                  out_stall,
  output xtea_pkg::xtea_out_t   out_data
);
  import xtea_pkg::*;

  logic      out_valid_r, out_valid_nxt;
  logic      skid_valid_r, skid_valid_nxt;
  xtea_out_t out_r, out_nxt;
  xtea_out_t skid_r, skid_nxt;
  xtea_out_t pipe_res;
  logic      take;
  logic      push;

  assign pipe_res = '{out_low: pipe_data.y, out_high: pipe_data.z};
  assign take     = out_valid_r && !out_stall;
  assign push     = pipe_valid && !skid_valid_r;

  // Refill the output from skid first, else from the pipeline
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    if (!out_valid_r || take) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        out_nxt        = pipe_res;
        out_valid_nxt  = push;
      end
    end else if (push) begin
      skid_nxt       = pipe_res;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign hold      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  // Skid only fills behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a transaction while the output is empty");

  // A transaction leaving the pipeline under a stall lands in the skid
  a_skid_catch: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall && pipe_valid && !skid_valid_r) |=> skid_valid_r)
    else $error("transaction lost at the stalled output");

  // A taken result with skid full is replaced by the skid entry
  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && !out_stall) |=> (out_valid_r && !skid_valid_r))
    else $error("skid did not drain into the output");
`endif

endmodule

>>> sv/xtea_block_cipher_unit.sv
// Top level of the XTEA block cipher unit: key registers, entry stage,
// half-round pipeline and output skid. Uses xtea_pkg and all xtea_ modules.
//
// Usage:
//   Key words 0..3 are written through cfg_we/cfg_index/cfg_data while the
//   unit is idle. Each input transaction carries kind (encrypt/decrypt),
//   the two block words and a valid byte count; short blocks are zero-padded
//   before encryption. Each input gives exactly one result transaction.
//   Throughput: one block per cycle while in_stall is low. The work is
//   unrolled into 2*ROUNDS half-round stages, one Feistel half-round each,
//   after an entry register. A result reaches out_valid through the entry
//   register, the half-round stages, then the output register.
//   Stalls: a stalled result waits in the output register; one more result
//   goes into a skid buffer, and while that is full the whole pipeline
//   holds and in_stall is high. Nothing is dropped or repeated.
//   Reset: synchronous, active low; clears all valid flags and key words.
module xtea_block_cipher_unit #(
  parameter int ROUNDS = xtea_pkg::XTEA_ROUNDS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  xtea_pkg::xtea_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output xtea_pkg::xtea_out_t out_data
);
  import xtea_pkg::*;

  localparam int HALVES = 2 * ROUNDS;

  xtea_key_t   key_r;
  logic        hold;
  logic        en;
  logic        stg_valid [0:HALVES];
  xtea_stage_t stg_data  [0:HALVES];

  // Key registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_we) begin
      case (xtea_cfg_idx_t'(cfg_index))
        KEY_WORD0: key_r[0] <= cfg_data;
        KEY_WORD1: key_r[1] <= cfg_data;
        KEY_WORD2: key_r[2] <= cfg_data;
        KEY_WORD3: key_r[3] <= cfg_data;
        default:   key_r    <= key_r;
      endcase
    end
  end

  // Pipeline moves whenever the skid is empty
  assign en       = !hold;
  assign in_stall = hold;

  xtea_pad u_pad (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .stg_valid (stg_valid[0]),
    .stg_data  (stg_data[0])
  );

  // Half-round stages
  for (genvar g = 0; g < HALVES; g++) begin : g_half
    xtea_half_round #(
      .ROUNDS (ROUNDS),
      .HALF   (g)
    ) u_half (
      .clk        (clk),
      .rst_n      (rst_n),
      .en         (en),
      .key        (key_r),
      .prev_valid (stg_valid[g]),
      .prev_data  (stg_data[g]),
      .stg_valid  (stg_valid[g+1]),
      .stg_data   (stg_data[g+1])
    );
  end

  xtea_out_skid u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .pipe_valid (stg_valid[HALVES]),
    .pipe_data  (stg_data[HALVES]),
    .hold       (hold),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

`ifndef SYNTHESIS
  // An accepted transaction enters the entry stage
  a_entry_load: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> stg_valid[0])
    else $error("accepted transaction missing from the entry stage");

  // While held, the last stage keeps its transaction
  a_hold_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (hold && stg_valid[HALVES]) |=> stg_valid[HALVES])
    else $error("last pipeline stage lost a transaction while held");

  // Key words only change on a configuration write
  a_key_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !cfg_we |=> $stable(key_r))
    else $error("key changed without a configuration write");
`endif

endmodule

>>> tb/xtea_block_cipher_unit_checker.sv
// Checker for the XTEA block cipher unit: mirrors the key words, predicts each
// block and compares it with the result channel. Uses xtea_pkg.
module xtea_block_cipher_unit_checker #(
  parameter int ROUNDS = xtea_pkg::XTEA_ROUNDS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic                in_valid,
  input  logic                in_stall,
  input  xtea_pkg::xtea_in_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  xtea_pkg::xtea_out_t out_data,
  output int                  pending_blocks,
  output int                  mismatch_count
);
  import xtea_pkg::*;

  localparam int MAX_REPORTS = 40;

  logic [31:0] key_words [4];
  xtea_out_t   expected_blocks [$];

  // Feistel mixing of one half
  function automatic logic [31:0] half_mix(input logic [31:0] v);
    return ((v << 4) ^ (v >> 5)) + v;
  endfunction

  // Full XTEA pass over one block with the given key
  function automatic xtea_out_t cipher_block(input xtea_in_t item,
                                             input logic [31:0] key [4]);
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] sum;
    logic [63:0] blk;
    xtea_out_t   res;
    y = item.block_low;
    z = item.block_high;
    if (item.kind == KIND_ENCRYPT) begin
      // short block: bytes past the count are cleared first
      if (item.valid_bytes >= 4'd1 && item.valid_bytes <= 4'd7) begin
        blk = {z, y};
        blk &= (64'd1 << (8 * item.valid_bytes)) - 64'd1;
        y = blk[31:0];
        z = blk[63:32];
      end
      sum = '0;
      for (int n = 0; n < ROUNDS; n++) begin
        y += half_mix(z) ^ (sum + key[sum[1:0]]);
        sum += XTEA_DELTA;
        z += half_mix(y) ^ (sum + key[sum[12:11]]);
      end
    end else begin
      // decrypt runs backwards from delta times the round count
      sum = XTEA_DELTA * 32'(ROUNDS);
      for (int n = 0; n < ROUNDS; n++) begin
        z -= half_mix(y) ^ (sum + key[sum[12:11]]);
        sum -= XTEA_DELTA;
        y -= half_mix(z) ^ (sum + key[sum[1:0]]);
      end
    end
    res.out_low  = y;
    res.out_high = z;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  // Watch both channels and the key port
  always @(posedge clk) begin
    xtea_out_t want;
    if (!rst_n) begin
      key_words = '{default: '0};
      expected_blocks.delete();
      mismatch_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_blocks.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h_%h",
                                    out_data.out_high, out_data.out_low));
        end else begin
          want = expected_blocks.pop_front();
          if (out_data.out_low !== want.out_low)
            report_mismatch($sformatf("out_low got %h want %h",
                                      out_data.out_low, want.out_low));
          if (out_data.out_high !== want.out_high)
            report_mismatch($sformatf("out_high got %h want %h",
                                      out_data.out_high, want.out_high));
        end
      end
      if (in_valid && !in_stall)
        expected_blocks.push_back(cipher_block(in_data, key_words));
      // key writes only happen while idle, so order against traffic is moot
      if (cfg_we)
        key_words[cfg_index] = cfg_data;
    end
    pending_blocks <= expected_blocks.size();
  end

endmodule

>>> tb/xtea_block_cipher_unit_tb.sv
// Testbench top for the XTEA block cipher unit: clock, reset, key loading,
// block stimulus and back-pressure. Uses xtea_pkg and the unit's checker.
module xtea_block_cipher_unit_tb;
  import xtea_pkg::*;

  localparam int ROUNDS           = XTEA_ROUNDS;
  localparam int LATENCY          = 2 * ROUNDS + 2;
  localparam int CYCLE_LIMIT      = 800000;
  localparam int HOLD_CYCLES      = 300;
  localparam int BLOCKS_PER_PHASE = 210;
  localparam int KEY_PHASES       = 6;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      cfg_we;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;
  logic      in_valid;
  logic      in_stall;
  xtea_in_t  in_data;
  logic      out_valid;
  logic      out_stall;
  xtea_out_t out_data;

  int pending_blocks;
  int mismatch_count;
  int cycle_count = 0;
  bit idling = 1'b1;
  bit hold_request = 1'b0;

  always #5 clk = ~clk;

  xtea_block_cipher_unit #(.ROUNDS(ROUNDS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  xtea_block_cipher_unit_checker #(.ROUNDS(ROUNDS)) cipher_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .pending_blocks (pending_blocks),
    .mismatch_count (mismatch_count)
  );

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Gap length: mostly none or short, now and then long
  function automatic int gap_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (!idling || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Result side back-pressure, with one long hold-off on request
  initial begin
    int r;
    int span;
    bit hold;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      hold = 1'b0;
      span = 1;
      if (hold_request) begin
        hold_request = 1'b0;
        hold = 1'b1;
        span = HOLD_CYCLES;
      end else if (idling) begin
        r = $urandom_range(0, 99);
        if (r < 35) begin
          hold = 1'b1;
          span = (r < 31) ? $urandom_range(1, 4) : $urandom_range(10, 60);
        end else begin
          span = $urandom_range(1, 6);
        end
      end
      out_stall <= hold;
      repeat (span) @(posedge clk);
    end
  end

  function automatic xtea_in_t make_block(input logic kind, input logic [31:0] lo,
                                          input logic [31:0] hi, input logic [3:0] cnt);
    xtea_in_t item;
    item.kind        = kind;
    item.block_low   = lo;
    item.block_high  = hi;
    item.valid_bytes = cnt;
    return item;
  endfunction

  // Random word, sometimes an extreme
  function automatic logic [31:0] random_word();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 32'h0000_0000;
    if (r == 1) return 32'hFFFF_FFFF;
    return $urandom();
  endfunction

  function automatic xtea_in_t random_block();
    int r;
    logic [3:0] cnt;
    r = $urandom_range(0, 99);
    if (r < 40)      cnt = 4'd8;
    else if (r < 80) cnt = 4'($urandom_range(1, 7));
    else             cnt = 4'($urandom_range(0, 15));
    return make_block($urandom_range(0, 1) ? KIND_DECRYPT : KIND_ENCRYPT,
                      random_word(), random_word(), cnt);
  endfunction

  // Offer one block until accepted, then an optional gap
  task automatic send_block(input xtea_in_t item);
    int gap;
    in_data  <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    gap = gap_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Four key writes back to back
  task automatic load_keys(input logic [31:0] k0, input logic [31:0] k1,
                           input logic [31:0] k2, input logic [31:0] k3);
    logic [31:0] words [4];
    words = '{k0, k1, k2, k3};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= 2'(KEY_WORD0 + i);
      cfg_data  <= words[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Stop offering, then wait until every transaction has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_blocks != 0) @(posedge clk);
  endtask

  // Stimulus
  initial begin
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= KEY_WORD0;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed blocks under the reset key
    send_block(make_block(KIND_ENCRYPT, 32'h0000_0000, 32'h0000_0000, 4'd8));
    send_block(make_block(KIND_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd8));
    for (int c = 1; c <= 7; c++)
      send_block(make_block(KIND_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'(c)));
    // zero and above eight mean a whole block
    send_block(make_block(KIND_ENCRYPT, 32'hA5A5_5A5A, 32'h1234_5678, 4'd0));
    send_block(make_block(KIND_ENCRYPT, 32'hA5A5_5A5A, 32'h1234_5678, 4'd9));
    send_block(make_block(KIND_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15));
    // decrypt ignores the count
    send_block(make_block(KIND_DECRYPT, 32'h0000_0000, 32'h0000_0000, 4'd8));
    send_block(make_block(KIND_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd8));
    send_block(make_block(KIND_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd1));
    send_block(make_block(KIND_DECRYPT, 32'hDEAD_BEEF, 32'h0BAD_F00D, 4'd0));
    send_block(make_block(KIND_DECRYPT, 32'hDEAD_BEEF, 32'h0BAD_F00D, 4'd15));

    // Random blocks, one key setting per phase
    for (int phase = 0; phase < KEY_PHASES; phase++) begin
      wait_drained();
      case (phase)
        0: load_keys('0, '0, '0, '0);
        1: load_keys('1, '1, '1, '1);
        2: load_keys(32'h0302_0100, 32'h0706_0504, 32'h0B0A_0908, 32'h0F0E_0D0C);
        default: load_keys($urandom(), $urandom(), $urandom(), $urandom());
      endcase
      idling = !(phase == 1 || phase == 4);
      if (phase == 3) hold_request = 1'b1;
      repeat (BLOCKS_PER_PHASE) send_block(random_block());
    end
    in_valid <= 1'b0;

    // Drain, then allow time for anything spurious to appear
    wait_drained();
    repeat (LATENCY + 8) @(posedge clk);
    if (mismatch_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
